@@ hw/rtl/arith_enc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arithmetic encoder package
// Default widths and the per-symbol output limit shared by the encoder.
// ----------------------------------------------------------------------------
package arith_enc_pkg;

	localparam int INTERVAL_BITS_DEF = 32;
	localparam int FREQ_BITS_DEF     = 16;
	localparam int PENDING_BITS_DEF  = 8;

	// most bytes one symbol may produce before it is dropped
	localparam int MAX_RESULTS = 40;

endpackage

@@ hw/rtl/arithmetic_encoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arithmetic encoder unit
// Multi-symbol arithmetic encoder: interval narrowing by a serial
// multiply-divide, E1/E2/E3 renormalisation, MSB-first byte packing, flush.
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+-----------------------------------
// cfg      | in  | cfg_valid/cfg_ready  | cfg_data = total_freq
// s (sym)  | in  | s_tvalid/s_tready    | s_tdata = cum_low, cum_high; s_tlast = finish
// m (code) | out | m_tvalid/m_tready    | m_tdata = out_byte; m_tuser = error; m_tlast = last
//
// Steps per symbol: acceptance, a load state, the radix-2 multiply-divide unit
// (run once for each bound) and a narrowing state; then the renormalisation steps plus a
// closing check, the emission of each code bit, the flush, a commit, and a read and a
// send for each output word.
// Reset is asynchronous and restores the coder state at once; no sweep.
// s_tready is high only between symbols; m_tready low simply holds the word.

module arithmetic_encoder_unit #(
	parameter int INTERVAL_BITS = arith_enc_pkg::INTERVAL_BITS_DEF,
	parameter int FREQ_BITS     = arith_enc_pkg::FREQ_BITS_DEF,
	parameter int PENDING_BITS  = arith_enc_pkg::PENDING_BITS_DEF,
	localparam int IN_W         = ((2 * FREQ_BITS + 1 + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [FREQ_BITS:0]   cfg_data,   // total_freq

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,    // cum_low, cum_high, zero pad
	input  logic                 s_tlast,    // finish

	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,    // out_byte
	output logic                 m_tuser,    // error
	output logic                 m_tlast     // last
);

	localparam int MAXR = arith_enc_pkg::MAX_RESULTS;
	localparam int RW   = INTERVAL_BITS + 1;
	localparam int CW   = $clog2(RW);
	localparam int IW   = $clog2(INTERVAL_BITS + 2);
	localparam int AW   = $clog2(MAXR);
	localparam int NW   = $clog2(MAXR + 1);
	localparam int F    = FREQ_BITS;

	localparam logic [INTERVAL_BITS-1:0] HALF_PT = {1'b1, {(INTERVAL_BITS-1){1'b0}}};
	localparam logic [INTERVAL_BITS-1:0] QTR1_PT = {2'b01, {(INTERVAL_BITS-2){1'b0}}};
	localparam logic [INTERVAL_BITS-1:0] QTR3_PT = {2'b11, {(INTERVAL_BITS-2){1'b0}}};

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_LOAD   = 11'b000_0000_0010,
		S_DIV    = 11'b000_0000_0100,
		S_NARROW = 11'b000_0000_1000,
		S_RENORM = 11'b000_0001_0000,
		S_EMIT   = 11'b000_0010_0000,
		S_FLUSH  = 11'b000_0100_0000,
		S_TAIL   = 11'b000_1000_0000,
		S_DONE   = 11'b001_0000_0000,
		S_READ   = 11'b010_0000_0000,
		S_SEND   = 11'b100_0000_0000
	} state_t;

	state_t                 state_q;
	logic [F:0]             tf_q;

	// committed coder state
	logic [INTERVAL_BITS-1:0] st_lo_q, st_hi_q;
	logic [PENDING_BITS-1:0] st_pend_q;
	logic [7:0]             st_acc_q;
	logic [2:0]             st_pos_q;

	// working copy for the symbol in flight
	logic [INTERVAL_BITS-1:0] w_lo_q, w_hi_q;
	logic [PENDING_BITS-1:0] w_pend_q;
	logic [7:0]             w_acc_q;
	logic [2:0]             w_pos_q;

	logic [F-1:0]           cl_q;
	logic [F:0]             ch_q;
	logic                   fin_q;

	logic [RW-1:0]          sh_q, quo_q, offh_q;
	logic [F-1:0]           rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   phase_q;
	logic [IW-1:0]          iter_q;

	logic                   em_bit_q, em_first_q, em_tail_q;
	logic [NW-1:0]          nb_q;
	logic [AW-1:0]          rd_q;
	logic                   out_err_q, out_last_q;
	logic [7:0]             rd_data_q;
	logic [7:0]             mem [MAXR];

	// multiply-divide step: quotient digit 0..2 per range bit
	logic [F:0]             c_sel;
	logic [F+1:0]           t_val, t_m1, t_m2;
	logic                   ge1, ge2;
	logic [F-1:0]           rem_n;
	logic [RW-1:0]          quo_n, rng_w, hi_calc, lo_calc;
	logic                   bad_range;

	always_comb begin
		c_sel = phase_q ? {1'b0, cl_q} : ch_q;
		t_val = {1'b0, rem_q, 1'b0} + ({1'b0, c_sel} & {(F+2){sh_q[RW-1]}});
		t_m1  = t_val - {1'b0, tf_q};
		t_m2  = t_val - {tf_q, 1'b0};
		ge2   = t_val >= {tf_q, 1'b0};
		ge1   = t_val >= {1'b0, tf_q};
		if (ge2) begin
			rem_n = t_m2[F-1:0];
		end else if (ge1) begin
			rem_n = t_m1[F-1:0];
		end else begin
			rem_n = t_val[F-1:0];
		end
		quo_n = {quo_q[RW-2:0], 1'b0} + {{(RW-2){1'b0}}, ge2, ge1 & ~ge2};
	end

	assign rng_w   = {1'b0, w_hi_q} - {1'b0, w_lo_q} + RW'(1);
	assign hi_calc = {1'b0, w_lo_q} + offh_q - RW'(1);
	assign lo_calc = {1'b0, w_lo_q} + quo_q;

	assign bad_range = (tf_q == '0) || (tf_q[F] && (tf_q[F-1:0] != '0)) ||
	                   ({1'b0, cl_q} >= ch_q) || (ch_q > tf_q) || (w_hi_q < w_lo_q);

	// renormalisation: one shared subtract and shift
	logic                   e1, e2, e3;
	logic [INTERVAL_BITS-1:0] sub_off, lo_sub, hi_sub;

	always_comb begin
		e1 = w_hi_q < HALF_PT;
		e2 = w_lo_q >= HALF_PT;
		e3 = (w_lo_q >= QTR1_PT) && (w_hi_q < QTR3_PT);
		if (e1) begin
			sub_off = '0;
		end else if (e2) begin
			sub_off = HALF_PT;
		end else begin
			sub_off = QTR1_PT;
		end
		lo_sub = w_lo_q - sub_off;
		hi_sub = w_hi_q - sub_off;
	end

	// bit packer
	logic                   emit_bit, byte_full, nb_full, more, pend_max;
	logic [7:0]             acc_set;
	logic [NW-1:0]          nb_m1;
	logic                   mem_we;
	logic [7:0]             mem_wd;

	always_comb begin
		emit_bit  = em_first_q ? em_bit_q : ~em_bit_q;
		acc_set   = emit_bit ? (w_acc_q | (8'h80 >> w_pos_q)) : w_acc_q;
		byte_full = w_pos_q == 3'd7;
		nb_full   = nb_q == NW'(MAXR);
		pend_max  = w_pend_q == {PENDING_BITS{1'b1}};
		more      = em_first_q ? (w_pend_q != '0) : (w_pend_q > PENDING_BITS'(1));
		nb_m1     = nb_q - NW'(1);
		mem_we    = 1'b0;
		mem_wd    = acc_set;
		if (state_q == S_EMIT) begin
			mem_we = byte_full && !nb_full;
		end else if (state_q == S_TAIL) begin
			mem_we = (w_pos_q != 3'd0) && !nb_full;
			mem_wd = w_acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[nb_q[AW-1:0]] <= mem_wd;
		end
		if (state_q == S_READ) begin
			rd_data_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tf_q       <= {{F{1'b0}}, 1'b1};
			st_lo_q    <= '0;
			st_hi_q    <= '1;
			st_pend_q  <= '0;
			st_acc_q   <= '0;
			st_pos_q   <= '0;
			w_lo_q     <= '0;
			w_hi_q     <= '1;
			w_pend_q   <= '0;
			w_acc_q    <= '0;
			w_pos_q    <= '0;
			cl_q       <= '0;
			ch_q       <= '0;
			fin_q      <= 1'b0;
			sh_q       <= '0;
			quo_q      <= '0;
			offh_q     <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			phase_q    <= 1'b0;
			iter_q     <= '0;
			em_bit_q   <= 1'b0;
			em_first_q <= 1'b0;
			em_tail_q  <= 1'b0;
			nb_q       <= '0;
			rd_q       <= '0;
			out_err_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tf_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cl_q     <= s_tdata[F-1:0];
						ch_q     <= s_tdata[2*F:F];
						fin_q    <= s_tlast;
						w_lo_q   <= st_lo_q;
						w_hi_q   <= st_hi_q;
						w_pend_q <= st_pend_q;
						w_acc_q  <= st_acc_q;
						w_pos_q  <= st_pos_q;
						nb_q     <= '0;
						state_q  <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (bad_range) begin
						out_err_q  <= 1'b1;
						out_last_q <= 1'b1;
						state_q    <= S_SEND;
					end else begin
						sh_q    <= rng_w;
						quo_q   <= '0;
						rem_q   <= '0;
						cnt_q   <= '0;
						phase_q <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					sh_q  <= {sh_q[RW-2:0], 1'b0};
					quo_q <= quo_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(RW - 1)) begin
						cnt_q <= '0;
						if (!phase_q) begin
							// upper bound done, rerun for the lower one
							offh_q  <= quo_n;
							phase_q <= 1'b1;
							sh_q    <= rng_w;
							quo_q   <= '0;
							rem_q   <= '0;
						end else begin
							state_q <= S_NARROW;
						end
					end
				end
				S_NARROW: begin
					if (quo_q >= offh_q) begin
						out_err_q  <= 1'b1;
						out_last_q <= 1'b1;
						state_q    <= S_SEND;
					end else begin
						w_hi_q  <= hi_calc[INTERVAL_BITS-1:0];
						w_lo_q  <= lo_calc[INTERVAL_BITS-1:0];
						iter_q  <= '0;
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					if ((iter_q == IW'(INTERVAL_BITS + 1)) || !(e1 || e2 || e3)) begin
						state_q <= fin_q ? S_FLUSH : S_DONE;
					end else if (!e1 && !e2 && pend_max) begin
						out_err_q  <= 1'b1;
						out_last_q <= 1'b1;
						state_q    <= S_SEND;
					end else begin
						iter_q <= iter_q + IW'(1);
						w_lo_q <= {lo_sub[INTERVAL_BITS-2:0], 1'b0};
						w_hi_q <= {hi_sub[INTERVAL_BITS-2:0], 1'b1};
						if (e1 || e2) begin
							em_bit_q   <= !e1;
							em_first_q <= 1'b1;
							em_tail_q  <= 1'b0;
							state_q    <= S_EMIT;
						end else begin
							// straddling the middle: defer the bit
							w_pend_q <= w_pend_q + PENDING_BITS'(1);
						end
					end
				end
				S_EMIT: begin
					if (byte_full && nb_full) begin
						out_err_q  <= 1'b1;
						out_last_q <= 1'b1;
						state_q    <= S_SEND;
					end else begin
						if (byte_full) begin
							nb_q    <= nb_q + NW'(1);
							w_acc_q <= '0;
							w_pos_q <= '0;
						end else begin
							w_acc_q <= acc_set;
							w_pos_q <= w_pos_q + 3'd1;
						end
						if (!em_first_q) begin
							w_pend_q <= w_pend_q - PENDING_BITS'(1);
						end
						em_first_q <= 1'b0;
						if (!more) begin
							state_q <= em_tail_q ? S_TAIL : S_RENORM;
						end
					end
				end
				S_FLUSH: begin
					if (pend_max) begin
						out_err_q  <= 1'b1;
						out_last_q <= 1'b1;
						state_q    <= S_SEND;
					end else begin
						w_pend_q   <= w_pend_q + PENDING_BITS'(1);
						em_bit_q   <= w_lo_q >= QTR1_PT;
						em_first_q <= 1'b1;
						em_tail_q  <= 1'b1;
						state_q    <= S_EMIT;
					end
				end
				S_TAIL: begin
					if ((w_pos_q != 3'd0) && nb_full) begin
						out_err_q  <= 1'b1;
						out_last_q <= 1'b1;
						state_q    <= S_SEND;
					end else begin
						if (w_pos_q != 3'd0) begin
							nb_q <= nb_q + NW'(1);
						end
						w_lo_q   <= '0;
						w_hi_q   <= '1;
						w_pend_q <= '0;
						w_acc_q  <= '0;
						w_pos_q  <= '0;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					st_lo_q   <= w_lo_q;
					st_hi_q   <= w_hi_q;
					st_pend_q <= w_pend_q;
					st_acc_q  <= w_acc_q;
					st_pos_q  <= w_pos_q;
					rd_q      <= '0;
					state_q   <= (nb_q == '0) ? S_IDLE : S_READ;
				end
				S_READ: begin
					out_err_q  <= 1'b0;
					out_last_q <= rd_q == nb_m1[AW-1:0];
					state_q    <= S_SEND;
				end
				S_SEND: begin
					if (m_tready) begin
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else begin
							rd_q    <= rd_q + AW'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = state_q == S_IDLE;
	assign m_tvalid  = state_q == S_SEND;
	assign m_tdata   = rd_data_q & {8{~out_err_q}};
	assign m_tuser   = out_err_q;
	assign m_tlast   = out_last_q;

	a_ready_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a word is offered");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("error word not marked last");

	a_interval_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RENORM) |-> (w_hi_q >= w_lo_q))
		else $error("coding interval inverted");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		nb_q <= NW'(MAXR))
		else $error("byte count beyond buffer");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_LOAD))
		else $error("accepted symbol not started");

endmodule
